[sv/rmq_pkg.sv]
package rmq_pkg;

    localparam int IN_W   = 24;
    localparam int NUM_W  = 25;
    localparam int QUOT_W = 25;
    localparam int THR_W  = 23;

    localparam logic [1:0] SEL_NORMAL = 2'd0;
    localparam logic [1:0] SEL_X      = 2'd1;
    localparam logic [1:0] SEL_Y      = 2'd2;
    localparam logic [1:0] SEL_Z      = 2'd3;

    localparam logic [22:0]        UQ_MAX  = 23'h7FFFFF;
    localparam logic signed [23:0] OUT_MAX = 24'sh7FFFFF;
    localparam logic signed [23:0] OUT_MIN = 24'sh800000;

    // Numerators of all three quotients for both paths
    typedef struct packed {
        logic signed [NUM_W-1:0] d1;
        logic signed [NUM_W-1:0] d2;
        logic signed [NUM_W-1:0] d3;
        logic signed [NUM_W-1:0] s01;
        logic signed [NUM_W-1:0] s02;
        logic signed [NUM_W-1:0] s12;
    } num_set_t;

    typedef struct packed {
        logic [1:0] sel;
        num_set_t   nums;
    } side_t;

    typedef struct packed {
        logic [1:0]        csel;
        logic [22:0]       e0q;
        logic signed [23:0] rtq;
    } tail_t;

endpackage

[sv/rmq_sqrt.sv]
module rmq_sqrt #(
    parameter int VW = 48
) (
    input  logic                  clk,
    input  logic                  en,
    input  logic [VW-1:0]         v,
    output logic [(VW+1)/2-1:0]   root
);
    localparam int RW = (VW + 1) / 2;
    localparam int SW = 2 * RW + 1;

    logic [SW-1:0] rem_reg  [RW];
    logic [RW-1:0] root_reg [RW];
    logic [SW-1:0] rem_in   [RW];
    logic [RW-1:0] root_in  [RW];

    // One result bit per stage, most significant first
    for (genvar s = 0; s < RW; s++) begin : g_stage
        localparam int B = RW - 1 - s;
        logic [SW-1:0] inc;
        if (s == 0) begin : g_first
            assign rem_in[s]  = SW'(v);
            assign root_in[s] = '0;
        end else begin : g_next
            assign rem_in[s]  = rem_reg[s-1];
            assign root_in[s] = root_reg[s-1];
        end
        assign inc = (SW'(root_in[s]) << (B + 1)) + (SW'(1) << (2 * B));
        always_ff @(posedge clk)
        begin
            if (en)
            begin
                if (rem_in[s] >= inc)
                begin
                    rem_reg[s]  <= rem_in[s] - inc;
                    root_reg[s] <= root_in[s] | (RW'(1) << B);
                end
                else
                begin
                    rem_reg[s]  <= rem_in[s];
                    root_reg[s] <= root_in[s];
                end
            end
        end
    end

    assign root = root_reg[RW-1];

endmodule

[sv/rmq_div.sv]
module rmq_div #(
    parameter int FRAC_BITS = 22,
    parameter int DW = 26
) (
    input  logic                        clk,
    input  logic                        en,
    input  logic signed [rmq_pkg::NUM_W-1:0] num,
    input  logic [DW-1:0]               den,
    output logic signed [23:0]          quot
);
    import rmq_pkg::*;

    localparam int AW = NUM_W + FRAC_BITS;
    localparam int CW = ((AW > DW + QUOT_W) ? AW : DW + QUOT_W) + 1;

    logic [NUM_W-1:0]  mag;
    logic [CW-1:0]     rem_reg [QUOT_W+1];
    logic [QUOT_W-1:0] q_reg   [QUOT_W+1];
    logic [DW-1:0]     d_reg   [QUOT_W+1];
    logic              neg_reg [QUOT_W+1];
    logic              ovf_reg [QUOT_W+1];
    logic [CW-1:0]     a0;
    logic [QUOT_W-1:0] f;
    logic              ovf_f;
    logic              neg_f;

    assign mag = num[NUM_W-1] ? NUM_W'(-num) : NUM_W'(num);
    assign a0  = CW'({mag, {FRAC_BITS{1'b0}}});

    // Stage 0: magnitude and overflow check against den * 2^QUOT_W
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            rem_reg[0] <= a0;
            q_reg[0]   <= '0;
            d_reg[0]   <= den;
            neg_reg[0] <= num[NUM_W-1];
            ovf_reg[0] <= a0 >= (CW'(den) << QUOT_W);
        end
    end

    for (genvar s = 1; s <= QUOT_W; s++) begin : g_stage
        localparam int B = QUOT_W - s;
        logic [CW-1:0] dsh;
        assign dsh = CW'(d_reg[s-1]) << B;
        always_ff @(posedge clk)
        begin
            if (en)
            begin
                d_reg[s]   <= d_reg[s-1];
                neg_reg[s] <= neg_reg[s-1];
                ovf_reg[s] <= ovf_reg[s-1];
                if (rem_reg[s-1] >= dsh)
                begin
                    rem_reg[s] <= rem_reg[s-1] - dsh;
                    q_reg[s]   <= q_reg[s-1] | (QUOT_W'(1) << B);
                end
                else
                begin
                    rem_reg[s] <= rem_reg[s-1];
                    q_reg[s]   <= q_reg[s-1];
                end
            end
        end
    end

    assign f     = q_reg[QUOT_W];
    assign ovf_f = ovf_reg[QUOT_W];
    assign neg_f = neg_reg[QUOT_W];

    // Saturate and apply sign
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            if (neg_f)
            begin
                if (ovf_f || f > QUOT_W'(24'h800000))
                    quot <= OUT_MIN;
                else
                    quot <= 24'(-f);
            end
            else
            begin
                if (ovf_f || f > QUOT_W'(24'h7FFFFF))
                    quot <= OUT_MAX;
                else
                    quot <= f[23:0];
            end
        end
    end

endmodule

[sv/rmq_front.sv]
module rmq_front #(
    parameter int FRAC_BITS = 22,
    parameter int NW = 28
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_ready,
    input  logic signed [23:0]   m00,
    input  logic signed [23:0]   m01,
    input  logic signed [23:0]   m02,
    input  logic signed [23:0]   m10,
    input  logic signed [23:0]   m11,
    input  logic signed [23:0]   m12,
    input  logic signed [23:0]   m20,
    input  logic signed [23:0]   m21,
    input  logic signed [23:0]   m22,
    input  logic                 q_full,
    output logic                 push,
    output logic signed [NW-1:0] n0,
    output logic signed [NW-1:0] nsel,
    output rmq_pkg::side_t       side
);
    import rmq_pkg::*;

    logic                 fv_reg;
    logic signed [NW-1:0] n0_reg, nsel_reg;
    side_t                side_reg;
    logic signed [NW-1:0] e00, e11, e22, one, trace, t0, n1, n2, n3, ns;
    logic [1:0]           sel;
    side_t                side_next;
    logic                 accept;

    assign e00   = NW'(m00);
    assign e11   = NW'(m11);
    assign e22   = NW'(m22);
    assign one   = NW'(1) << FRAC_BITS;
    assign trace = e00 + e11 + e22;
    assign t0    = trace + one;
    assign n1    = one + (e00 <<< 1) - trace;
    assign n2    = one + (e11 <<< 1) - trace;
    assign n3    = one + (e22 <<< 1) - trace;

    // Largest square, ties to the later index
    always_comb
    begin
        if (n1 > n2)
            sel = (n1 > n3) ? SEL_X : SEL_Z;
        else
            sel = (n2 > n3) ? SEL_Y : SEL_Z;
        unique case (sel)
            SEL_X:   ns = n1;
            SEL_Y:   ns = n2;
            default: ns = n3;
        endcase
    end

    always_comb
    begin
        side_next.sel      = sel;
        side_next.nums.d1  = NUM_W'(m21) - NUM_W'(m12);
        side_next.nums.d2  = NUM_W'(m02) - NUM_W'(m20);
        side_next.nums.d3  = NUM_W'(m10) - NUM_W'(m01);
        side_next.nums.s01 = NUM_W'(m10) + NUM_W'(m01);
        side_next.nums.s02 = NUM_W'(m20) + NUM_W'(m02);
        side_next.nums.s12 = NUM_W'(m21) + NUM_W'(m12);
    end

    assign push     = fv_reg && !q_full;
    assign in_ready = !fv_reg || !q_full;
    assign accept   = in_valid && in_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            fv_reg <= 1'b0;
        else if (accept)
            fv_reg <= 1'b1;
        else if (push)
            fv_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            n0_reg   <= t0;
            nsel_reg <= ns;
            side_reg <= side_next;
        end
    end

    assign n0   = n0_reg;
    assign nsel = nsel_reg;
    assign side = side_reg;

endmodule

[sv/rmq_queue.sv]
module rmq_queue #(
    parameter int W = 8
) (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         push,
    input  logic [W-1:0] wdata,
    input  logic         pop,
    output logic [W-1:0] rdata,
    output logic         full,
    output logic         empty
);
    logic [W-1:0] mem_reg [2];
    logic         wr_ptr_reg, rd_ptr_reg;
    logic [1:0]   count_reg;

    assign full  = count_reg == 2'd2;
    assign empty = count_reg == 2'd0;
    assign rdata = mem_reg[rd_ptr_reg];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            if (push)
                wr_ptr_reg <= !wr_ptr_reg;
            if (pop)
                rd_ptr_reg <= !rd_ptr_reg;
            if (push && !pop)
                count_reg <= count_reg + 2'd1;
            else if (pop && !push)
                count_reg <= count_reg - 2'd1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
            mem_reg[wr_ptr_reg] <= wdata;
    end

    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        !(push && full)) else $error("push into full queue");
    a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
        !(pop && empty)) else $error("pop from empty queue");

endmodule

[sv/rmq_back.sv]
module rmq_back #(
    parameter int FRAC_BITS = 22,
    parameter int NW = 28
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         q_empty,
    output logic                         q_pop,
    input  logic signed [NW-1:0]         q_n0,
    input  logic signed [NW-1:0]         q_nsel,
    input  rmq_pkg::side_t               q_side,
    input  logic [rmq_pkg::THR_W-1:0]    thr,
    output logic                         out_valid,
    input  logic                         out_ready,
    output logic [22:0]                  q_scalar,
    output logic signed [23:0]           q_x,
    output logic signed [23:0]           q_y,
    output logic signed [23:0]           q_z,
    output logic [1:0]                   case_taken
);
    import rmq_pkg::*;

    localparam int VW = NW - 1 + FRAC_BITS - 2;
    localparam int RW = (VW + 1) / 2;
    localparam int DW = RW + 2;
    localparam int CW = (RW > 24) ? RW : 24;
    localparam int SL = RW;
    localparam int DL = QUOT_W + 2;

    logic              en;
    logic [VW-1:0]     v0, vs;
    logic [RW-1:0]     e0, rt;
    logic [SL-1:0]     sv_reg;
    side_t             sd_reg [SL];
    side_t             sd;
    logic              near;
    logic              bv_reg;
    tail_t             bt_reg;
    logic [DW-1:0]     den_reg;
    logic signed [NUM_W-1:0] n1_reg, n2_reg, n3_reg;
    logic [DL-1:0]     tv_reg;
    tail_t             tt_reg [DL];
    tail_t             tt;
    logic signed [23:0] qd1, qd2, qd3;
    logic              out_valid_reg;
    logic [22:0]       q_scalar_reg;
    logic signed [23:0] q_x_reg, q_y_reg, q_z_reg;
    logic [1:0]        case_taken_reg;

    // Advance the whole back end unless the output is held
    assign en    = !out_valid_reg || out_ready;
    assign q_pop = en && !q_empty;

    assign v0 = q_n0[NW-1]   ? '0 : {q_n0[NW-2:0],   {(FRAC_BITS-2){1'b0}}};
    assign vs = q_nsel[NW-1] ? '0 : {q_nsel[NW-2:0], {(FRAC_BITS-2){1'b0}}};

    rmq_sqrt #(.VW(VW)) u_sqrt_e0  (.clk(clk), .en(en), .v(v0), .root(e0));
    rmq_sqrt #(.VW(VW)) u_sqrt_sel (.clk(clk), .en(en), .v(vs), .root(rt));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sv_reg <= '0;
            bv_reg <= 1'b0;
            tv_reg <= '0;
        end
        else if (en)
        begin
            sv_reg <= {sv_reg[SL-2:0], q_pop};
            bv_reg <= sv_reg[SL-1];
            tv_reg <= {tv_reg[DL-2:0], bv_reg};
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            sd_reg[0] <= q_side;
            for (int i = 1; i < SL; i++)
                sd_reg[i] <= sd_reg[i-1];
            tt_reg[0] <= bt_reg;
            for (int i = 1; i < DL; i++)
                tt_reg[i] <= tt_reg[i-1];
        end
    end

    assign sd   = sd_reg[SL-1];
    assign near = CW'(e0) < CW'(thr);

    // Pick path: divisor and numerators for the three dividers
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            bt_reg.csel <= near ? sd.sel : SEL_NORMAL;
            bt_reg.e0q  <= near ? '0 :
                           ((CW'(e0) > CW'(UQ_MAX)) ? UQ_MAX : 23'(e0));
            bt_reg.rtq  <= (CW'(rt) > CW'(UQ_MAX)) ? OUT_MAX : 24'(rt);
            den_reg     <= near ? {rt, 2'b00} : {e0, 2'b00};
            if (!near)
            begin
                n1_reg <= sd.nums.d1;
                n2_reg <= sd.nums.d2;
                n3_reg <= sd.nums.d3;
            end
            else
            begin
                unique case (sd.sel)
                    SEL_X:
                    begin
                        n1_reg <= sd.nums.s01;
                        n2_reg <= sd.nums.s01;
                        n3_reg <= sd.nums.s02;
                    end
                    SEL_Y:
                    begin
                        n1_reg <= sd.nums.s01;
                        n2_reg <= sd.nums.s12;
                        n3_reg <= sd.nums.s12;
                    end
                    default:
                    begin
                        n1_reg <= sd.nums.s02;
                        n2_reg <= sd.nums.s12;
                        n3_reg <= sd.nums.s12;
                    end
                endcase
            end
        end
    end

    rmq_div #(.FRAC_BITS(FRAC_BITS), .DW(DW)) u_div1
        (.clk(clk), .en(en), .num(n1_reg), .den(den_reg), .quot(qd1));
    rmq_div #(.FRAC_BITS(FRAC_BITS), .DW(DW)) u_div2
        (.clk(clk), .en(en), .num(n2_reg), .den(den_reg), .quot(qd2));
    rmq_div #(.FRAC_BITS(FRAC_BITS), .DW(DW)) u_div3
        (.clk(clk), .en(en), .num(n3_reg), .den(den_reg), .quot(qd3));

    assign tt = tt_reg[DL-1];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (en)
            out_valid_reg <= tv_reg[DL-1];
    end

    // Output register: the chosen square's root replaces its quotient
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            q_scalar_reg   <= tt.e0q;
            case_taken_reg <= tt.csel;
            q_x_reg <= (tt.csel == SEL_X) ? tt.rtq : qd1;
            q_y_reg <= (tt.csel == SEL_Y) ? tt.rtq : qd2;
            q_z_reg <= (tt.csel == SEL_Z) ? tt.rtq : qd3;
        end
    end

    assign out_valid  = out_valid_reg;
    assign q_scalar   = q_scalar_reg;
    assign q_x        = q_x_reg;
    assign q_y        = q_y_reg;
    assign q_z        = q_z_reg;
    assign case_taken = case_taken_reg;

    a_near_scalar_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && case_taken_reg != SEL_NORMAL) |-> q_scalar_reg == '0)
        else $error("near-zero result with nonzero scalar");
    a_hold_pipe: assert property (@(posedge clk) disable iff (!rst_n)
        !en |=> ($stable(sv_reg) && $stable(tv_reg) && $stable(bv_reg)))
        else $error("pipeline moved while output held");

endmodule

[sv/rotation_matrix_to_quaternion_top.sv]
// Rotation matrix to quaternion (Euler parameters) converter.
// Input channel: in_valid/in_ready with the nine matrix entries m00..m22,
// signed fixed point with FRAC_BITS fraction bits. Output channel:
// out_valid/out_ready with q_scalar, q_x, q_y, q_z and case_taken.
// Configuration: cfg_write/cfg_data load the near-zero threshold at any edge;
// write it only while no item is in flight.
// Throughput: one item per cycle while out_ready stays high.
// Pipeline at the default FRAC_BITS: the front register loads at the accepting
// edge; then queue register + square root pipeline (one stage per root bit,
// RW = (NW+FRAC_BITS-2)/2, 24 at the default) + path select register + divider
// pipeline (input register, 25 quotient steps and a saturation register) +
// output register; the two root units and three 25-step dividers dominate it.
// Reset clears all valid flags and the queue and loads the threshold with 4.
// When the receiver stalls, the whole back end holds; the two-entry queue
// and the front register keep taking items until they fill, then in_ready
// drops.
module rotation_matrix_to_quaternion_top #(
    parameter int FRAC_BITS = 22
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               cfg_write,
    input  logic [22:0]        cfg_data,
    input  logic               in_valid,
    output logic               in_ready,
    input  logic signed [23:0] m00,
    input  logic signed [23:0] m01,
    input  logic signed [23:0] m02,
    input  logic signed [23:0] m10,
    input  logic signed [23:0] m11,
    input  logic signed [23:0] m12,
    input  logic signed [23:0] m20,
    input  logic signed [23:0] m21,
    input  logic signed [23:0] m22,
    output logic               out_valid,
    input  logic               out_ready,
    output logic [22:0]        q_scalar,
    output logic signed [23:0] q_x,
    output logic signed [23:0] q_y,
    output logic signed [23:0] q_z,
    output logic [1:0]         case_taken
);
    import rmq_pkg::*;

    // Radicand numerators need room for ONE plus three diagonal entries
    localparam int NW = (FRAC_BITS + 3 > 28) ? FRAC_BITS + 3 : 28;
    localparam int SW = $bits(side_t);
    localparam int QW = 2 * NW + SW;

    logic [THR_W-1:0]     thr_reg;
    logic                 push, pop, q_full, q_empty;
    logic signed [NW-1:0] f_n0, f_nsel;
    side_t                f_side;
    logic [QW-1:0]        q_wdata, q_rdata;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            thr_reg <= THR_W'(4);
        else if (cfg_write)
            thr_reg <= cfg_data;
    end

    // Front: sums, radicand numerators and choice of square
    rmq_front #(.FRAC_BITS(FRAC_BITS), .NW(NW)) u_front (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_ready(in_ready),
        .m00(m00), .m01(m01), .m02(m02),
        .m10(m10), .m11(m11), .m12(m12),
        .m20(m20), .m21(m21), .m22(m22),
        .q_full(q_full), .push(push),
        .n0(f_n0), .nsel(f_nsel), .side(f_side)
    );

    assign q_wdata = {f_n0, f_nsel, f_side};

    // Decouple front from the back-end stall
    rmq_queue #(.W(QW)) u_queue (
        .clk(clk), .rst_n(rst_n),
        .push(push), .wdata(q_wdata),
        .pop(pop), .rdata(q_rdata),
        .full(q_full), .empty(q_empty)
    );

    // Back: roots, path select, dividers, output register
    rmq_back #(.FRAC_BITS(FRAC_BITS), .NW(NW)) u_back (
        .clk(clk), .rst_n(rst_n),
        .q_empty(q_empty), .q_pop(pop),
        .q_n0(q_rdata[QW-1 -: NW]),
        .q_nsel(q_rdata[SW +: NW]),
        .q_side(q_rdata[SW-1:0]),
        .thr(thr_reg),
        .out_valid(out_valid), .out_ready(out_ready),
        .q_scalar(q_scalar), .q_x(q_x), .q_y(q_y), .q_z(q_z),
        .case_taken(case_taken)
    );

endmodule

[verif/rmq_checker.sv]
module rmq_checker (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               cfg_write,
    input  logic [22:0]        cfg_data,
    input  logic               in_valid,
    input  logic               in_ready,
    input  logic signed [23:0] m00,
    input  logic signed [23:0] m01,
    input  logic signed [23:0] m02,
    input  logic signed [23:0] m10,
    input  logic signed [23:0] m11,
    input  logic signed [23:0] m12,
    input  logic signed [23:0] m20,
    input  logic signed [23:0] m21,
    input  logic signed [23:0] m22,
    input  logic               out_valid,
    input  logic               out_ready,
    input  logic [22:0]        q_scalar,
    input  logic signed [23:0] q_x,
    input  logic signed [23:0] q_y,
    input  logic signed [23:0] q_z,
    input  logic [1:0]         case_taken,
    output int                 fail_count,
    output int                 pending
);
    import rmq_pkg::*;

    localparam int FB = 22;

    typedef struct packed {
        logic [22:0]        e0;
        logic signed [23:0] e1;
        logic signed [23:0] e2;
        logic signed [23:0] e3;
        logic [1:0]         sel;
    } quat_t;

    quat_t       quat_q[$];
    logic [22:0] threshold;

    function automatic longint isqrt(longint unsigned v);
        longint unsigned r;
        longint unsigned b;
        r = 0;
        b = 64'd1 << 62;
        while (b > v) b = b >> 2;
        while (b != 0) begin
            if (v >= r + b) begin
                v = v - (r + b);
                r = (r >> 1) + b;
            end else begin
                r = r >> 1;
            end
            b = b >> 2;
        end
        return longint'(r);
    endfunction

    function automatic longint quarter_root(longint n);
        if (n < 0) n = 0;
        return isqrt(longint'(n) << (FB - 2));
    endfunction

    function automatic longint clip24(longint v);
        if (v > 8388607) return 8388607;
        if (v < -8388608) return -8388608;
        return v;
    endfunction

    function automatic longint sdiv(longint num, longint rt);
        if (rt == 0) return (num < 0) ? -8388608 : 8388607;
        return clip24((num * (64'sd1 <<< FB)) / (4 * rt));
    endfunction

    function automatic quat_t convert(longint a00, longint a01, longint a02,
                                      longint a10, longint a11, longint a12,
                                      longint a20, longint a21, longint a22,
                                      logic [22:0] thr);
        quat_t  q;
        longint one, tr, e0, n1, n2, n3, s01, s02, s12, rt;
        longint e1, e2, e3;
        logic [1:0] sel;
        one = 64'sd1 <<< FB;
        tr = a00 + a11 + a22;
        e0 = quarter_root(tr + one);
        sel = SEL_NORMAL;
        if (e0 < longint'(thr)) begin
            n1 = one + 2 * a00 - tr;
            n2 = one + 2 * a11 - tr;
            n3 = one + 2 * a22 - tr;
            s01 = a10 + a01;
            s02 = a20 + a02;
            s12 = a21 + a12;
            if (n1 > n2) sel = (n1 > n3) ? SEL_X : SEL_Z;
            else sel = (n2 > n3) ? SEL_Y : SEL_Z;
            e0 = 0;
            if (sel == SEL_X) begin
                rt = quarter_root(n1);
                e1 = clip24(rt); e2 = sdiv(s01, rt); e3 = sdiv(s02, rt);
            end else if (sel == SEL_Y) begin
                rt = quarter_root(n2);
                e2 = clip24(rt); e1 = sdiv(s01, rt); e3 = sdiv(s12, rt);
            end else begin
                rt = quarter_root(n3);
                e3 = clip24(rt); e1 = sdiv(s02, rt); e2 = sdiv(s12, rt);
            end
        end else begin
            e1 = sdiv(a21 - a12, e0);
            e2 = sdiv(a02 - a20, e0);
            e3 = sdiv(a10 - a01, e0);
        end
        q.e0 = (e0 > 8388607) ? UQ_MAX : e0[22:0];
        q.e1 = e1[23:0];
        q.e2 = e2[23:0];
        q.e3 = e3[23:0];
        q.sel = sel;
        return q;
    endfunction

    always @(posedge clk or negedge rst_n) begin
        quat_t w;
        if (!rst_n) begin
            threshold = 23'd4;
            fail_count = 0;
            quat_q.delete();
        end else begin
            if (in_valid && in_ready)
                quat_q.push_back(convert(m00, m01, m02, m10, m11, m12,
                                         m20, m21, m22, threshold));
            if (out_valid && out_ready) begin
                if (quat_q.size() == 0) begin
                    $error("unexpected result item");
                    fail_count++;
                end else begin
                    w = quat_q.pop_front();
                    if (q_scalar !== w.e0) begin
                        $error("q_scalar exp %0d got %0d", w.e0, q_scalar);
                        fail_count++;
                    end
                    if (q_x !== w.e1) begin
                        $error("q_x exp %0d got %0d", w.e1, q_x);
                        fail_count++;
                    end
                    if (q_y !== w.e2) begin
                        $error("q_y exp %0d got %0d", w.e2, q_y);
                        fail_count++;
                    end
                    if (q_z !== w.e3) begin
                        $error("q_z exp %0d got %0d", w.e3, q_z);
                        fail_count++;
                    end
                    if (case_taken !== w.sel) begin
                        $error("case_taken exp %0d got %0d", w.sel, case_taken);
                        fail_count++;
                    end
                end
            end
            if (cfg_write) threshold = cfg_data;
        end
        pending = quat_q.size();
    end
endmodule

[verif/rotation_matrix_to_quaternion_top_tb.sv]
module rotation_matrix_to_quaternion_top_tb;
    import rmq_pkg::*;

    logic clk, rst_n, cfg_write, in_valid, in_ready, out_valid, out_ready;
    logic [22:0] cfg_data, q_scalar;
    logic signed [23:0] m00, m01, m02, m10, m11, m12, m20, m21, m22;
    logic signed [23:0] q_x, q_y, q_z;
    logic [1:0] case_taken;
    int fail_count, pending;
    int send_idle, recv_stall;

    localparam logic signed [23:0] ONE = 24'sh400000;
    localparam logic signed [23:0] MONE = -24'sh400000;

    rotation_matrix_to_quaternion_top u_dut (.*);

    rmq_checker u_chk (.*);

    initial begin
        clk = 0;
        forever #4 clk = ~clk;
    end

    // Generous fixed limit on the whole run
    initial begin
        #20000000;
        $display("tb: failure");
        $finish;
    end

    // Receiver: stall out_ready at the current phase's rate
    always @(posedge clk or negedge rst_n) begin
        if (!rst_n) out_ready <= 1'b0;
        else out_ready <= ($urandom_range(99) >= recv_stall);
    end

    // Offer one matrix item and hold it until accepted; random idle first.
    // Valid stays high after acceptance unless an idle gap follows.
    task automatic send_matrix(input logic signed [23:0] a [9]);
        if ($urandom_range(99) < send_idle) begin
            in_valid <= 1'b0;
            @(posedge clk);
            while ($urandom_range(99) < send_idle) @(posedge clk);
        end
        in_valid <= 1'b1;
        {m00, m01, m02, m10, m11, m12, m20, m21, m22}
            <= {a[0], a[1], a[2], a[3], a[4], a[5], a[6], a[7], a[8]};
        @(posedge clk);
        while (!in_ready) @(posedge clk);
    endtask

    // Drain the pipeline, then allow the threshold to be written
    task automatic drain();
        in_valid <= 1'b0;
        @(posedge clk);
        while (pending != 0) @(posedge clk);
        repeat (70) @(posedge clk);
    endtask

    task automatic write_threshold(input logic [22:0] v);
        cfg_write <= 1'b1;
        cfg_data <= v;
        @(posedge clk);
        cfg_write <= 1'b0;
    endtask

    // Random matrix: signed permutations with small perturbations, bounded
    // random entries (some with a near-180 diagonal) and raw noise, to steer all paths
    task automatic random_matrix(output logic signed [23:0] a [9]);
        int k, p, i;
        k = $urandom_range(9);
        for (i = 0; i < 9; i++) a[i] = '0;
        if (k < 3) begin
            for (i = 0; i < 9; i++) a[i] = 24'($urandom);
        end else if (k < 6) begin
            // signed permutation matrix with jitter
            p = $urandom_range(2);
            for (i = 0; i < 3; i++)
                a[i * 3 + (i + p) % 3] = $urandom_range(1) ? ONE : MONE;
            for (i = 0; i < 9; i++)
                a[i] = a[i] + $signed(24'($urandom_range(2047))) - 24'sd1024;
        end else begin
            // random bounded entries with near-180 diagonal bias
            for (i = 0; i < 9; i++)
                a[i] = $signed(24'($urandom_range(8388607))) - 24'sh400000;
            if (k == 9) begin
                p = $urandom_range(2);
                for (i = 0; i < 3; i++) a[i * 4] = (i == p) ? ONE : MONE;
            end
        end
    endtask

    initial begin
        logic signed [23:0] a [9];
        logic [22:0] thr [4];
        int phase, n;
        thr = '{23'd4, 23'd0, 23'h7FFFFF, 23'd40000};
        rst_n = 0; cfg_write = 0; cfg_data = 0; in_valid = 0;
        {m00, m01, m02, m10, m11, m12, m20, m21, m22} = '0;
        send_idle = 0; recv_stall = 0;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: identity, 180 deg turns about each axis, ties, extremes
        a = '{ONE, 0, 0, 0, ONE, 0, 0, 0, ONE};             send_matrix(a);
        a = '{ONE, 0, 0, 0, MONE, 0, 0, 0, MONE};           send_matrix(a);
        a = '{MONE, 0, 0, 0, ONE, 0, 0, 0, MONE};           send_matrix(a);
        a = '{MONE, 0, 0, 0, MONE, 0, 0, 0, ONE};           send_matrix(a);
        a = '{MONE, 0, 0, 0, MONE, 0, 0, 0, MONE};          send_matrix(a);
        a = '{0, ONE, 0, ONE, 0, 0, 0, 0, MONE};            send_matrix(a);
        a = '{24'sh800000, 24'sh800000, 24'sh800000, 24'sh800000, 24'sh800000,
              24'sh800000, 24'sh800000, 24'sh800000, 24'sh800000};
        send_matrix(a);
        a = '{24'sh7FFFFF, 24'sh7FFFFF, 24'sh7FFFFF, 24'sh7FFFFF, 24'sh7FFFFF,
              24'sh7FFFFF, 24'sh7FFFFF, 24'sh7FFFFF, 24'sh7FFFFF};
        send_matrix(a);
        a = '{24'sh7FFFFF, 24'sh800000, 24'sh7FFFFF, 24'sh800000, 24'sh7FFFFF,
              24'sh800000, 24'sh7FFFFF, 24'sh800000, 24'sh7FFFFF};
        send_matrix(a);
        a = '{24'sh800000, 24'sh7FFFFF, 24'sh800000, 24'sh7FFFFF, 0,
              24'sh7FFFFF, 24'sh800000, 24'sh7FFFFF, 24'sh800000};
        send_matrix(a);
        a = '{0, 24'sh7FFFFF, 24'sh800000, 24'sh800000, 0, 24'sh7FFFFF,
              24'sh7FFFFF, 24'sh800000, 0};
        send_matrix(a);
        a = '{MONE, 5, 0, 5, MONE, 0, 0, 0, 0};             send_matrix(a);
        a = '{0, 0, 0, 0, 0, 0, 0, 0, 0};                   send_matrix(a);

        // Hold off until every expected result has come
        drain();

        // Random phases: thresholds include zero and the maximum
        for (phase = 0; phase < 4; phase++) begin
            write_threshold(thr[phase]);
            case (phase)
                0: begin send_idle = 0;  recv_stall = 0;  end
                1: begin send_idle = 85; recv_stall = 0;  end
                2: begin send_idle = 0;  recv_stall = 85; end
                default: begin send_idle = 29; recv_stall = 29; end
            endcase
            for (n = 0; n < 110; n++) begin
                random_matrix(a);
                send_matrix(a);
            end
            drain();
        end

        repeat (60) @(posedge clk);
        if (fail_count == 0) $display("tb: success");
        else $display("tb: failure");
        $finish;
    end
endmodule
